### sv/penv_pkg.sv
// Shared widths, register codes, reset values and rounding helper for the piano envelope.
`timescale 1ns / 1ps

package penv_pkg;

  localparam int TIME_BITS   = 24;
  localparam int SAMPLE_BITS = 16;
  localparam int GAIN_BITS   = 32;
  localparam int GAIN_FRAC   = 30;
  localparam int STEP_BITS   = 30;
  localparam int PROD_BITS   = SAMPLE_BITS + GAIN_BITS;
  localparam int SH_BITS     = PROD_BITS - GAIN_FRAC + 1;
  localparam int DIV_CNT_BITS = $clog2(GAIN_FRAC);
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = (TIME_BITS > STEP_BITS) ? TIME_BITS : STEP_BITS;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_ATTACK      = 3'd0,
    CFG_RELEASE     = 3'd1,
    CFG_NOTE        = 3'd2,
    CFG_DECAY_START = 3'd3,
    CFG_PEDAL_NOTE  = 3'd4,
    CFG_PEDAL_TAIL  = 3'd5,
    CFG_STEP_NORMAL = 3'd6,
    CFG_STEP_PEDAL  = 3'd7
  } cfg_idx_e;

  localparam logic [TIME_BITS-1:0] ATTACK_RST      = TIME_BITS'(441);
  localparam logic [TIME_BITS-1:0] RELEASE_RST     = TIME_BITS'(44);
  localparam logic [TIME_BITS-1:0] NOTE_RST        = TIME_BITS'(4410);
  localparam logic [TIME_BITS-1:0] DECAY_START_RST = TIME_BITS'(44100);
  localparam logic [TIME_BITS-1:0] PEDAL_NOTE_RST  = TIME_BITS'(1323000);
  localparam logic [TIME_BITS-1:0] PEDAL_TAIL_RST  = TIME_BITS'(13230);
  localparam logic [STEP_BITS-1:0] STEP_NORMAL_RST = STEP_BITS'(6087);
  localparam logic [STEP_BITS-1:0] STEP_PEDAL_RST  = STEP_BITS'(487);

  // Unity gain in Q2.30 and the rounding half-LSB of the product.
  localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << GAIN_FRAC;
  localparam logic [PROD_BITS:0]   ROUND_HALF = (PROD_BITS + 1)'(1) << (GAIN_FRAC - 1);

  // Round a Q1.15 x Q2.30 product back to Q1.15 (floor after half add), saturate.
  function automatic logic [SAMPLE_BITS-1:0] round_sat(input logic [PROD_BITS-1:0] prod);
    logic [PROD_BITS:0]            sum;
    logic [SH_BITS-1:0]            sh;
    logic [SH_BITS-SAMPLE_BITS:0]  upper;
    logic [SAMPLE_BITS-1:0]        res;
    sum   = {prod[PROD_BITS-1], prod} + ROUND_HALF;
    sh    = sum[PROD_BITS:GAIN_FRAC];
    upper = sh[SH_BITS-1:SAMPLE_BITS-1];
    if ((&upper) || (~|upper)) begin
      res = sh[SAMPLE_BITS-1:0];
    end else if (sh[SH_BITS-1]) begin
      res = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      res = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

### sv/penv_div.sv
// Restoring divider producing the Q0.30 ramp gain num * 2^30 / den, one bit per cycle.
`timescale 1ns / 1ps

module penv_div (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start_i,
  input  logic [penv_pkg::TIME_BITS-1:0]        num_i,
  input  logic [penv_pkg::TIME_BITS-1:0]        den_i,
  output logic                                  done_o,
  output logic [penv_pkg::GAIN_FRAC-1:0]        quot_o
);

  logic                                  busy_q;
  logic                                  done_q;
  logic [penv_pkg::DIV_CNT_BITS-1:0]     cnt_q;
  logic [penv_pkg::TIME_BITS-1:0]        rem_q, rem_d;
  logic [penv_pkg::TIME_BITS-1:0]        den_q;
  logic [penv_pkg::GAIN_FRAC-1:0]        quo_q;
  logic [penv_pkg::TIME_BITS:0]          rem2;
  logic [penv_pkg::TIME_BITS+1:0]        diff;
  logic                                  ge;

  // Shift the partial remainder and try one subtract of the divisor.
  assign rem2  = {rem_q, 1'b0};
  assign diff  = {1'b0, rem2} - {2'b00, den_q};
  assign ge    = ~diff[penv_pkg::TIME_BITS+1];
  assign rem_d = ge ? diff[penv_pkg::TIME_BITS-1:0] : rem2[penv_pkg::TIME_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= penv_pkg::DIV_CNT_BITS'(penv_pkg::GAIN_FRAC - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - penv_pkg::DIV_CNT_BITS'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[penv_pkg::GAIN_FRAC-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### sv/penv_mul.sv
// Shared sample-by-gain multiplier with registered product and Q1.15 round and saturate.
`timescale 1ns / 1ps

module penv_mul (
  input  logic                                  clk_i,
  input  logic [penv_pkg::SAMPLE_BITS-1:0]      sample_i,
  input  logic [penv_pkg::GAIN_BITS-1:0]        gain_i,
  output logic [penv_pkg::SAMPLE_BITS-1:0]      res_o
);

  logic signed [penv_pkg::PROD_BITS-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= penv_pkg::PROD_BITS'($signed(sample_i)) *
              penv_pkg::PROD_BITS'($signed(gain_i));
  end

  assign res_o = penv_pkg::round_sat(prod_q);

endmodule

### sv/piano_envelope_sustain_pedal.sv
// Top level of the piano envelope: config registers, sequencer and result register.
`timescale 1ns / 1ps

// Stereo gain envelope for one piano voice with a sustain pedal. Each input word is either a
// start command (time cleared, note length reloaded, silent result with active low) or one
// stereo sample pair, which is scaled by a Q2.30 gain chosen from an attack ramp, a release
// ramp before the note end, a slow decay after the decay start, or unity, and returned as
// saturated Q1.15 with active high until time reaches the note length. Items are processed one
// at a time: in_stall_o stays high from acceptance until the result is loaded into the output
// register and drops the cycle after. A sample in either ramp passes a prepare step, the
// bit-serial divider that makes 30 quotient bits one per cycle, the left, right and end
// multiply steps and the finish step; a sample at unity or decay gain skips the divider,
// a finished note goes from the prepare step to the finish step and a start command goes
// straight to it. Both products go through the one shared multiplier that scales left then
// right. The output register holds a result while out_stall_i is high, and the next word may
// be accepted meanwhile. Configuration writes are taken at any edge with cfg_we_i high.
module piano_envelope_sustain_pedal (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // configuration write port
  input  logic                                   cfg_we_i,
  input  logic [penv_pkg::CFG_IDX_BITS-1:0]      cfg_idx_i,
  input  logic [penv_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  // input channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic                                   command_i,
  input  logic [penv_pkg::SAMPLE_BITS-1:0]       sample_left_i,
  input  logic [penv_pkg::SAMPLE_BITS-1:0]       sample_right_i,
  input  logic                                   sustain_pedal_i,
  // output channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [penv_pkg::SAMPLE_BITS-1:0]       out_left_o,
  output logic [penv_pkg::SAMPLE_BITS-1:0]       out_right_o,
  output logic                                   active_o
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_PREP  = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_MUL_L = 7'b0001000,
    S_MUL_R = 7'b0010000,
    S_MUL_E = 7'b0100000,
    S_FIN   = 7'b1000000
  } state_e;

  localparam int TB = penv_pkg::TIME_BITS;
  localparam int SB = penv_pkg::SAMPLE_BITS;
  localparam int GB = penv_pkg::GAIN_BITS;
  localparam int GF = penv_pkg::GAIN_FRAC;
  localparam int ST = penv_pkg::STEP_BITS;

  state_e state_q, state_d;

  // configuration registers
  logic [TB-1:0] attack_q, release_q, note_q, decay_start_q, pedal_note_q, pedal_tail_q;
  logic [ST-1:0] step_normal_q, step_pedal_q;

  // voice state
  logic [TB-1:0] time_q, len_q;
  logic [GB-1:0] last_gain_q;
  logic          held_q;

  // per-word working registers
  logic [SB-1:0] left_q, right_q;
  logic          pedal_q;
  logic [GB-1:0] gain_q;
  logic [SB-1:0] res_l_q, res_r_q;
  logic          res_act_q;

  // result register
  logic          out_valid_q;
  logic [SB-1:0] out_left_q, out_right_q;
  logic          out_act_q;

  logic          in_accept;
  logic          fin_load;
  logic [TB-1:0] remain;
  logic [GB-1:0] step_ext;
  logic [GB-1:0] decay_gain;
  logic          div_start;
  logic [TB-1:0] div_num, div_den;
  logic          div_done;
  logic [GF-1:0] div_quot;
  logic [SB-1:0] mul_sample;
  logic [SB-1:0] mul_res;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign fin_load   = (state_q == S_FIN) && (!out_valid_q || !out_stall_i);

  // Configuration writes; every 3-bit index maps to a register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_q      <= penv_pkg::ATTACK_RST;
      release_q     <= penv_pkg::RELEASE_RST;
      note_q        <= penv_pkg::NOTE_RST;
      decay_start_q <= penv_pkg::DECAY_START_RST;
      pedal_note_q  <= penv_pkg::PEDAL_NOTE_RST;
      pedal_tail_q  <= penv_pkg::PEDAL_TAIL_RST;
      step_normal_q <= penv_pkg::STEP_NORMAL_RST;
      step_pedal_q  <= penv_pkg::STEP_PEDAL_RST;
    end else if (cfg_we_i) begin
      case (penv_pkg::cfg_idx_e'(cfg_idx_i))
        penv_pkg::CFG_ATTACK:      attack_q      <= cfg_data_i[TB-1:0];
        penv_pkg::CFG_RELEASE:     release_q     <= cfg_data_i[TB-1:0];
        penv_pkg::CFG_NOTE:        note_q        <= cfg_data_i[TB-1:0];
        penv_pkg::CFG_DECAY_START: decay_start_q <= cfg_data_i[TB-1:0];
        penv_pkg::CFG_PEDAL_NOTE:  pedal_note_q  <= cfg_data_i[TB-1:0];
        penv_pkg::CFG_PEDAL_TAIL:  pedal_tail_q  <= cfg_data_i[TB-1:0];
        penv_pkg::CFG_STEP_NORMAL: step_normal_q <= cfg_data_i[ST-1:0];
        penv_pkg::CFG_STEP_PEDAL:  step_pedal_q  <= cfg_data_i[ST-1:0];
        default: ;
      endcase
    end
  end

  // Time that leaves pedal_tail to the note end (zero if shorter); loaded on a pedal lift.
  assign remain = (len_q > pedal_tail_q) ? (len_q - pedal_tail_q) : '0;

  // Decay moves the last gain one step toward zero.
  assign step_ext   = {{(GB-ST){1'b0}}, (pedal_q ? step_pedal_q : step_normal_q)};
  assign decay_gain = last_gain_q[GB-1] ? (last_gain_q + step_ext) : (last_gain_q - step_ext);

  // Ramp divisions: attack uses elapsed time, release uses time to the end.
  always_comb begin
    div_start = 1'b0;
    div_num   = time_q;
    div_den   = attack_q;
    if (state_q == S_PREP && time_q < len_q) begin
      if (time_q < attack_q) begin
        div_start = 1'b1;
      end else if ((len_q - time_q) < release_q) begin
        div_start = 1'b1;
        div_num   = len_q - time_q;
        div_den   = release_q;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = command_i ? S_FIN : S_PREP;
        end
      end
      S_PREP: begin
        if (!(time_q < len_q)) begin
          state_d = S_FIN;
        end else if (div_start) begin
          state_d = S_DIV;
        end else begin
          state_d = S_MUL_L;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_MUL_L;
        end
      end
      S_MUL_L: state_d = S_MUL_R;
      S_MUL_R: state_d = S_MUL_E;
      S_MUL_E: state_d = S_FIN;
      S_FIN: begin
        if (fin_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer and voice state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      time_q      <= '0;
      len_q       <= penv_pkg::NOTE_RST;
      last_gain_q <= '0;
      held_q      <= 1'b0;
      res_act_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept) begin
        if (command_i) begin
          time_q    <= '0;
          len_q     <= note_q;
          res_act_q <= 1'b0;
        end else if (sustain_pedal_i) begin
          len_q  <= pedal_note_q;
          held_q <= 1'b1;
        end else if (held_q) begin
          time_q <= remain;
          held_q <= 1'b0;
        end
      end
      if (state_q == S_PREP) begin
        res_act_q <= (time_q < len_q);
      end
      if (fin_load && res_act_q) begin
        last_gain_q <= gain_q;
        time_q      <= time_q + TB'(1);
      end
      if (fin_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: samples, chosen gain, scaled results and output word.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      left_q  <= sample_left_i;
      right_q <= sample_right_i;
      pedal_q <= sustain_pedal_i;
      res_l_q <= '0;
      res_r_q <= '0;
    end
    if (state_q == S_PREP) begin
      gain_q <= (time_q > decay_start_q) ? decay_gain : penv_pkg::GAIN_ONE;
    end
    if (state_q == S_DIV && div_done) begin
      gain_q <= {{(GB-GF){1'b0}}, div_quot};
    end
    if (state_q == S_MUL_R) begin
      res_l_q <= mul_res;
    end
    if (state_q == S_MUL_E) begin
      res_r_q <= mul_res;
    end
    if (fin_load) begin
      out_left_q  <= res_l_q;
      out_right_q <= res_r_q;
      out_act_q   <= res_act_q;
    end
  end

  penv_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Scale left first, then right, through the one multiplier.
  assign mul_sample = (state_q == S_MUL_L) ? left_q : right_q;

  penv_mul u_mul (
    .clk_i    (clk_i),
    .sample_i (mul_sample),
    .gain_i   (gain_q),
    .res_o    (mul_res)
  );

  assign out_valid_o = out_valid_q;
  assign out_left_o  = out_left_q;
  assign out_right_o = out_right_q;
  assign active_o    = out_act_q;

`ifndef SYNTHESIS
  a_valid_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_FIN))
    else $error("result word appeared outside the finish step");

  a_silent_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_act_q) |-> (out_left_q == '0 && out_right_q == '0))
    else $error("inactive result word carries nonzero samples");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV))
    else $error("divider finished outside the divide step");

  a_ramp_gain_below_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && div_done) |=> (gain_q[GB-1:GF] == '0))
    else $error("ramp gain reached unity or above");

  a_time_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_load && res_act_q) |=> (time_q == $past(time_q) + TB'(1)))
    else $error("note time did not advance after a sounding sample");
`endif

endmodule
